// ===== design/dsrt_pkg.sv =====
// Shared types, codes and helpers for the date-sorted record table.
`timescale 1ns / 1ps
`default_nettype none

package dsrt_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 31;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int SLOT_W    = 4;
	localparam int STATUS_W  = 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_FOUND    = 2'd2,
		ST_MISSING  = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} rec_t;

	// Broadcast from the top level to every cell in the chain.
	typedef struct packed {
		logic ins;    // an insert beat was accepted and the table has room
		logic front;  // the new record goes to the front of the list
	} cell_cmd_t;

	// True when the date of a is newer than or equal to the date of b.
	function automatic logic date_ge(rec_t a, rec_t b);
		return {a.month, a.day} >= {b.month, b.day};
	endfunction

endpackage

`default_nettype wire

// ===== design/dsrt_cell.sv =====
// One storage cell of the record chain: holds a record, shifts from its left neighbor.
`timescale 1ns / 1ps
`default_nettype none

module dsrt_cell #(
	parameter bit FIRST = 1'b0
) (
	input  wire logic              clk,
	input  wire logic              occ,
	input  wire dsrt_pkg::cell_cmd_t cmd,
	input  wire dsrt_pkg::rec_t    key,
	input  wire dsrt_pkg::rec_t    left_rec,
	input  wire logic              left_g,
	output dsrt_pkg::rec_t         rec_q,
	output logic                   g,
	output logic                   take,
	output logic                   match
);

	logic f;
	logic shift;

	// The front cell takes ties; later cells keep equal dates ahead of the new one.
	always_comb begin
		if (FIRST) begin
			f = !occ || dsrt_pkg::date_ge(key, rec_q);
			g = f;
		end else begin
			f = !occ || !dsrt_pkg::date_ge(rec_q, key);
			g = f || cmd.front;
		end
		shift = cmd.ins && left_g;
		take  = cmd.ins && g && !left_g;
		match = occ && (rec_q.id == key.id);
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= left_rec;
		end else if (take) begin
			rec_q <= key;
		end
	end

endmodule

`default_nettype wire

// ===== design/dsrt_pick.sv =====
// Picks the lowest flagged cell and gathers its position and record.
`timescale 1ns / 1ps
`default_nettype none

module dsrt_pick #(
	parameter int DEPTH = dsrt_pkg::DEPTH_DEF
) (
	input  wire logic [DEPTH-1:0]          sel,
	input  wire dsrt_pkg::rec_t            recs [DEPTH],
	output logic [dsrt_pkg::SLOT_W-1:0]    slot,
	output dsrt_pkg::rec_t                 rec
);

	logic [DEPTH-1:0] first;

	// Isolating the lowest set bit costs one increment across the vector.
	assign first = sel & (~sel + {{(DEPTH-1){1'b0}}, 1'b1});

	always_comb begin
		slot = '0;
		rec  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				slot = slot | dsrt_pkg::SLOT_W'(i);
				rec  = dsrt_pkg::rec_t'(rec | recs[i]);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/date_sorted_record_table.sv =====
// Top level of the date-sorted record table: cell chain, selection and output register.
`timescale 1ns / 1ps
`default_nettype none

// The table keeps up to DEPTH records (identifier, month, day) sorted newest
// first, with dates compared by month and then by day. An insert beat places
// its record at the front when the table is empty or the new date is newer
// than or equal to the front date, and otherwise right after every entry
// whose date is not older; a full table drops the insert and answers with a
// full status. A lookup beat answers with the record nearest the front whose
// identifier matches, or a not-found status. Every input beat yields exactly
// one result beat, registered, on the cycle after acceptance. The block takes
// one beat per cycle: every cell compares its record with the broadcast key
// and shifts in parallel, and the cycle is set by the lowest-bit isolation
// and the gather across the DEPTH cells. The input is stalled only while a
// result waits on a stalled output. Slot numbers carry the low four bits of
// the position. Reset empties the table; no clearing pass is needed.
module date_sorted_record_table #(
	parameter int DEPTH = dsrt_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	input  wire logic [dsrt_pkg::ID_W-1:0]     rec_id,
	input  wire logic [dsrt_pkg::MONTH_W-1:0]  month,
	input  wire logic [dsrt_pkg::DAY_W-1:0]    day,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [dsrt_pkg::STATUS_W-1:0]      status,
	output logic [dsrt_pkg::SLOT_W-1:0]        slot,
	output logic [dsrt_pkg::ID_W-1:0]          found_id,
	output logic [dsrt_pkg::MONTH_W-1:0]       found_month,
	output logic [dsrt_pkg::DAY_W-1:0]         found_day
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                  acc;
	logic                  is_lookup;
	logic                  full;
	logic [CNT_W-1:0]      entry_count_q;
	dsrt_pkg::rec_t        key;
	dsrt_pkg::cell_cmd_t   cmd;
	dsrt_pkg::rec_t        cell_rec [DEPTH];
	logic [DEPTH-1:0]      occ;
	logic [DEPTH-1:0]      g;
	logic [DEPTH-1:0]      take;
	logic [DEPTH-1:0]      match;
	logic [DEPTH-1:0]      sel;
	logic [dsrt_pkg::SLOT_W-1:0] pick_slot;
	dsrt_pkg::rec_t        pick_rec;
	logic                  out_valid_q;
	dsrt_pkg::status_t     status_q;
	logic [dsrt_pkg::SLOT_W-1:0] slot_q;
	dsrt_pkg::rec_t        found_q;

	// A new beat is refused only while a result sits on a stalled output.
	assign in_stall  = out_valid_q && out_stall;
	assign acc       = in_valid && !in_stall;
	assign is_lookup = (op == dsrt_pkg::OP_LOOKUP);
	assign full      = (entry_count_q == CNT_W'(DEPTH));

	assign key.id    = rec_id;
	assign key.month = month;
	assign key.day   = day;

	assign cmd.ins   = acc && !is_lookup && !full;
	assign cmd.front = g[0];

	// The occupied cells always form a prefix of the chain.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = (CNT_W'(i) < entry_count_q);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			dsrt_cell #(
				.FIRST(1'b1)
			) u_cell (
				.clk     (clk),
				.occ     (occ[i]),
				.cmd     (cmd),
				.key     (key),
				.left_rec('0),
				.left_g  (1'b0),
				.rec_q   (cell_rec[i]),
				.g       (g[i]),
				.take    (take[i]),
				.match   (match[i])
			);
		end else begin : g_body
			dsrt_cell #(
				.FIRST(1'b0)
			) u_cell (
				.clk     (clk),
				.occ     (occ[i]),
				.cmd     (cmd),
				.key     (key),
				.left_rec(cell_rec[i-1]),
				.left_g  (g[i-1]),
				.rec_q   (cell_rec[i]),
				.g       (g[i]),
				.take    (take[i]),
				.match   (match[i])
			);
		end
	end

	// An insert with room marks exactly one taking cell; a lookup marks every matching cell.
	assign sel = is_lookup ? match : take;

	dsrt_pick #(
		.DEPTH(DEPTH)
	) u_pick (
		.sel (sel),
		.recs(cell_rec),
		.slot(pick_slot),
		.rec (pick_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.ins) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; fields without meaning are forced to zero.
	always_ff @(posedge clk) begin
		if (acc) begin
			if (!is_lookup) begin
				found_q <= '0;
				if (full) begin
					status_q <= dsrt_pkg::ST_FULL;
					slot_q   <= '0;
				end else begin
					status_q <= dsrt_pkg::ST_INSERTED;
					slot_q   <= pick_slot;
				end
			end else if (|match) begin
				status_q <= dsrt_pkg::ST_FOUND;
				slot_q   <= pick_slot;
				found_q  <= pick_rec;
			end else begin
				status_q <= dsrt_pkg::ST_MISSING;
				slot_q   <= '0;
				found_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign found_id    = found_q.id;
	assign found_month = found_q.month;
	assign found_day   = found_q.day;

	// The fill count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	// An insert with room marks exactly one cell to take the new record.
	a_one_taker: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> $onehot(take))
		else $error("insert without exactly one target cell");

	// An accepted insert with room grows the table by one entry.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> entry_count_q == $past(entry_count_q) + CNT_W'(1))
		else $error("insert did not grow the table");

	// Every accepted beat is followed by a result beat on the output.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_valid)
		else $error("accepted beat produced no result");

endmodule

`default_nettype wire
